FILE: hdl/rawt_pkg.sv
`timescale 1ns / 1ps
package rawt_pkg;

  localparam int unsigned RING_SECTORS = 16384;
  localparam int unsigned SLOT_W       = 14;
  localparam int unsigned FILL_W       = 15;
  localparam int unsigned LBA_W        = 24;
  localparam int unsigned CNT_W        = 12;
  localparam int unsigned TAG_W        = 8;
  localparam int unsigned LEN_W        = 7;
  localparam int unsigned MAX_BURST    = 64;

  localparam int unsigned IN_DATA_W    = 56;
  localparam int unsigned OUT_DATA_W   = 96;
  localparam int unsigned ADDR_W       = 5;

  typedef enum logic [1:0] {
    CMD_QUERY      = 2'd0,
    CMD_READ       = 2'd1,
    CMD_FETCH_REQ  = 2'd2,
    CMD_FETCH_DONE = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    REG_ACTIVE      = 3'd0,
    REG_TOTAL       = 3'd1,
    REG_BURST_LEN   = 3'd2,
    REG_FIRST_LEN   = 3'd3,
    REG_BEHIND_KEEP = 3'd4,
    REG_SLACK_LEN   = 3'd5
  } reg_idx_e;

  localparam logic [LEN_W-1:0] BURST_LEN_RST   = 7'd32;
  localparam logic [LEN_W-1:0] FIRST_LEN_RST   = 7'd8;
  localparam logic [CNT_W-1:0] BEHIND_KEEP_RST = 12'd256;
  localparam logic [CNT_W-1:0] SLACK_LEN_RST   = 12'd256;

  typedef struct packed {
    logic [FILL_W-1:0] level;
    logic [TAG_W-1:0]  fetch_tag;
    logic [LEN_W-1:0]  fetch_len;
    logic [LBA_W-1:0]  fetch_lba;
    logic              fetch_valid;
    logic [CNT_W-1:0]  zero_count;
    logic [CNT_W-1:0]  served;
    logic [SLOT_W-1:0] ring_slot;
    logic              seek;
    logic              hit;
  } result_t;

endpackage

FILE: hdl/readahead_window_tracker_top.sv
`timescale 1ns / 1ps
// Control block of a sector read-ahead ring of 16384 slots.
// Commands enter on the s_axis channel: tuser carries the command (query, read,
// fetch request, fetch done) and tdata the request fields. Every command gives
// exactly one result on the m_axis channel: hit and seek flags, ring slot,
// served and zero-fill counts, the burst to fetch and the window level.
// Six registers (active, total sectors, burst and first lengths, trailing
// margin, slack) sit on the APB port at byte addresses 0 to 20. The user must
// see that they are written only while no command is in flight; the block
// itself does not enforce it. A command is held in an input register and
// evaluated against the window base, fill and generation tag, which update at
// the same edge as the result register, where tvalid also rises. Throughput
// is one command per cycle while the receiver takes results; each command
// reads the window state as the command before it left it.
// When the receiver stalls, the result register holds and the input register
// still takes one more command; after that tready drops until the result
// is taken.
// Reset clears both stages, the window state and the registers to their
// default values. Writing active from 0 to 1 also clears the window state.
module readahead_window_tracker_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // lba, count, tag, fetched, zero padding
  input  logic [rawt_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // cmd
  input  logic [1:0]                         s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // hit, seek, ring_slot, served, zero_count, fetch_valid, fetch_lba,
  // fetch_len, fetch_tag, level, zero padding
  output logic [rawt_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [rawt_pkg::ADDR_W-1:0]        paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);
  import rawt_pkg::*;

  localparam logic [FILL_W-1:0] RING_FILL = FILL_W'(RING_SECTORS);

  logic              active_q;
  logic [LBA_W-1:0]  total_q;
  logic [LEN_W-1:0]  burst_q;
  logic [LEN_W-1:0]  first_q;
  logic [CNT_W-1:0]  behind_q;
  logic [CNT_W-1:0]  slack_q;

  logic [LBA_W-1:0]  base_q, base_d;
  logic [FILL_W-1:0] fill_q, fill_d;
  logic [TAG_W-1:0]  epoch_q, epoch_d;

  logic              in_valid_q;
  cmd_e              in_cmd_q;
  logic [LBA_W-1:0]  in_lba_q;
  logic [CNT_W-1:0]  in_count_q;
  logic [TAG_W-1:0]  in_tag_q;
  logic [LEN_W-1:0]  in_fetched_q;

  logic              out_valid_q;
  result_t           res_q, res_d;

  logic              adv;
  logic              in_take;
  logic              cfg_wr;
  logic              cfg_clear;
  reg_idx_e          cfg_idx;

  logic [LBA_W:0]    head;
  logic [LBA_W+1:0]  slack_head;
  logic              lba_in_disc;
  logic [LBA_W-1:0]  t_minus_lba;
  logic [LBA_W:0]    lba_plus_cnt;
  logic [LBA_W-1:0]  req_end;
  logic              win_hit;
  logic              win_seek;
  logic [LBA_W-1:0]  new_base;
  logic [LBA_W-1:0]  base_gap;
  logic [FILL_W-1:0] base_step;
  logic              head_in_disc;
  logic [LBA_W-1:0]  left_len;
  logic              fill_room;
  logic [FILL_W-1:0] room_len;
  logic [LEN_W-1:0]  want_len;
  logic [LEN_W-1:0]  clamp_len;
  logic [LEN_W-1:0]  room_cut;
  logic [LEN_W-1:0]  req_len;
  logic [LEN_W-1:0]  done_room_cut;
  logic [LEN_W-1:0]  done_len;
  logic [CNT_W-1:0]  served_len;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = reg_idx_e'(paddr[ADDR_W-1:2]);
  assign cfg_clear = cfg_wr && (cfg_idx == REG_ACTIVE) && pwdata[0] && !active_q;

  always_comb begin
    prdata = '0;
    case (cfg_idx)
      REG_ACTIVE:      prdata = {31'd0, active_q};
      REG_TOTAL:       prdata = {8'd0, total_q};
      REG_BURST_LEN:   prdata = {25'd0, burst_q};
      REG_FIRST_LEN:   prdata = {25'd0, first_q};
      REG_BEHIND_KEEP: prdata = {20'd0, behind_q};
      REG_SLACK_LEN:   prdata = {20'd0, slack_q};
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      total_q  <= '0;
      burst_q  <= BURST_LEN_RST;
      first_q  <= FIRST_LEN_RST;
      behind_q <= BEHIND_KEEP_RST;
      slack_q  <= SLACK_LEN_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_ACTIVE:      active_q <= pwdata[0];
        REG_TOTAL:       total_q  <= pwdata[LBA_W-1:0];
        REG_BURST_LEN:   burst_q  <= pwdata[LEN_W-1:0];
        REG_FIRST_LEN:   first_q  <= pwdata[LEN_W-1:0];
        REG_BEHIND_KEEP: behind_q <= pwdata[CNT_W-1:0];
        REG_SLACK_LEN:   slack_q  <= pwdata[CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign adv           = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || adv;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_cmd_q     <= cmd_e'(s_axis_tuser);
      in_lba_q     <= s_axis_tdata[23:0];
      in_count_q   <= s_axis_tdata[35:24];
      in_tag_q     <= s_axis_tdata[43:36];
      in_fetched_q <= s_axis_tdata[50:44];
    end
  end

  // Window checks shared by query and read.
  assign head         = {1'b0, base_q} + {{(LBA_W+1-FILL_W){1'b0}}, fill_q};
  assign slack_head   = {1'b0, head} + {{(LBA_W+2-CNT_W){1'b0}}, slack_q};
  assign lba_in_disc  = in_lba_q < total_q;
  assign t_minus_lba  = total_q - in_lba_q;
  assign lba_plus_cnt = {1'b0, in_lba_q} + {{(LBA_W+1-CNT_W){1'b0}}, in_count_q};
  assign req_end      = ({{(LBA_W-CNT_W){1'b0}}, in_count_q} > t_minus_lba) ?
                        total_q : lba_plus_cnt[LBA_W-1:0];
  assign win_hit      = (in_lba_q >= base_q) && ({1'b0, req_end} <= head);
  assign win_seek     = !win_hit &&
                        ((in_lba_q < base_q) || ({2'b0, in_lba_q} > slack_head));
  assign served_len   = CNT_W'(req_end - in_lba_q);

  // Trailing-margin advance of the base after a read hit.
  assign new_base  = (req_end > {{(LBA_W-CNT_W){1'b0}}, behind_q}) ?
                     (req_end - {{(LBA_W-CNT_W){1'b0}}, behind_q}) : '0;
  assign base_gap  = new_base - base_q;
  assign base_step = (new_base <= base_q) ? '0 :
                     ((base_gap > {{(LBA_W-FILL_W){1'b0}}, fill_q}) ?
                      fill_q : base_gap[FILL_W-1:0]);

  // Fetch sizing, shared by request and done.
  assign head_in_disc = head < {1'b0, total_q};
  assign left_len     = head_in_disc ? LBA_W'({1'b0, total_q} - head) : '0;
  assign fill_room    = fill_q < RING_FILL;
  assign room_len     = fill_room ? (RING_FILL - fill_q) : '0;
  assign want_len     = (fill_q != '0) ? burst_q : first_q;
  assign clamp_len    = (want_len == '0) ? LEN_W'(1) :
                        ((want_len > LEN_W'(MAX_BURST)) ? LEN_W'(MAX_BURST) : want_len);
  assign room_cut     = ({{(FILL_W-LEN_W){1'b0}}, clamp_len} > room_len) ?
                        room_len[LEN_W-1:0] : clamp_len;
  assign req_len      = ({{(LBA_W-LEN_W){1'b0}}, room_cut} > left_len) ?
                        left_len[LEN_W-1:0] : room_cut;
  assign done_room_cut = ({{(FILL_W-LEN_W){1'b0}}, in_fetched_q} > room_len) ?
                         room_len[LEN_W-1:0] : in_fetched_q;
  assign done_len      = ({{(LBA_W-LEN_W){1'b0}}, done_room_cut} > left_len) ?
                         left_len[LEN_W-1:0] : done_room_cut;

  always_comb begin
    res_d   = '0;
    base_d  = base_q;
    fill_d  = fill_q;
    epoch_d = epoch_q;
    case (in_cmd_q)
      CMD_QUERY: begin
        if (!active_q || !lba_in_disc) begin
          res_d.hit = 1'b1;
        end else if (win_hit) begin
          res_d.hit       = 1'b1;
          res_d.ring_slot = in_lba_q[SLOT_W-1:0];
        end else if (win_seek) begin
          res_d.seek = 1'b1;
          epoch_d    = epoch_q + TAG_W'(1);
          base_d     = in_lba_q;
          fill_d     = '0;
        end
      end
      CMD_READ: begin
        if (active_q && (in_count_q != '0)) begin
          if (!lba_in_disc) begin
            res_d.hit        = 1'b1;
            res_d.zero_count = in_count_q;
          end else if (win_hit) begin
            res_d.hit        = 1'b1;
            res_d.ring_slot  = in_lba_q[SLOT_W-1:0];
            res_d.served     = served_len;
            res_d.zero_count = in_count_q - served_len;
            base_d = base_q + {{(LBA_W-FILL_W){1'b0}}, base_step};
            fill_d = fill_q - base_step;
          end else if (win_seek) begin
            res_d.seek = 1'b1;
            epoch_d    = epoch_q + TAG_W'(1);
            base_d     = in_lba_q;
            fill_d     = '0;
          end
        end
      end
      CMD_FETCH_REQ: begin
        if (active_q && head_in_disc && fill_room) begin
          res_d.fetch_valid = 1'b1;
          res_d.fetch_lba   = head[LBA_W-1:0];
          res_d.fetch_len   = req_len;
          res_d.fetch_tag   = epoch_q;
          res_d.ring_slot   = head[SLOT_W-1:0];
        end
      end
      CMD_FETCH_DONE: begin
        if (active_q && (in_tag_q == epoch_q)) begin
          res_d.hit       = 1'b1;
          res_d.ring_slot = head[SLOT_W-1:0];
          fill_d = fill_q + {{(FILL_W-LEN_W){1'b0}}, done_len};
        end
      end
      default: begin
      end
    endcase
    res_d.level = fill_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  <= '0;
      fill_q  <= '0;
      epoch_q <= '0;
    end else if (cfg_clear) begin
      base_q  <= '0;
      fill_q  <= '0;
      epoch_q <= '0;
    end else if (adv) begin
      base_q  <= base_d;
      fill_q  <= fill_d;
      epoch_q <= epoch_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, res_q};

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= RING_FILL)
    else $error("window fill above ring size");

  a_seek_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.seek |-> !res_q.hit)
    else $error("seek reported together with hit");

  a_fetch_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.fetch_valid |-> (res_q.fetch_len != '0) &&
    (res_q.fetch_len <= LEN_W'(MAX_BURST)))
    else $error("fetch issued with bad length");

  a_req_keeps_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && (in_cmd_q == CMD_FETCH_REQ) && !cfg_clear |=>
    (base_q == $past(base_q)) && (fill_q == $past(fill_q)) &&
    (epoch_q == $past(epoch_q)))
    else $error("fetch request changed window state");

  a_level_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && !cfg_clear |=> res_q.level == fill_q)
    else $error("reported level differs from window fill");

endmodule

FILE: tb/sv/rawt_window_checker.sv
`timescale 1ns / 1ps
module rawt_window_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_tvalid_i,
  input  logic                            s_tready_i,
  input  logic [rawt_pkg::IN_DATA_W-1:0]  s_tdata_i,
  input  logic [1:0]                      s_tuser_i,
  input  logic                            m_tvalid_i,
  input  logic                            m_tready_i,
  input  logic [rawt_pkg::OUT_DATA_W-1:0] m_tdata_i,
  input  logic                            psel_i,
  input  logic                            penable_i,
  input  logic                            pwrite_i,
  input  logic [rawt_pkg::ADDR_W-1:0]     paddr_i,
  input  logic [31:0]                     pwdata_i,
  input  logic                            pready_i,
  output int unsigned                     mismatches_o,
  output int unsigned                     outstanding_o,
  output int unsigned                     checked_o,
  output int unsigned                     seeks_o,
  output logic [rawt_pkg::TAG_W-1:0]      epoch_o,
  output logic [rawt_pkg::LBA_W-1:0]      base_o,
  output logic [rawt_pkg::FILL_W-1:0]     fill_o
);
  import rawt_pkg::*;

  localparam int unsigned CNT_LSB = LBA_W;
  localparam int unsigned TAG_LSB = CNT_LSB + CNT_W;
  localparam int unsigned FET_LSB = TAG_LSB + TAG_W;

  logic              act_q;
  logic [LBA_W-1:0]  disc_sectors;
  logic [LEN_W-1:0]  burst_sectors;
  logic [LEN_W-1:0]  first_sectors;
  logic [CNT_W-1:0]  keep_sectors;
  logic [CNT_W-1:0]  slack_sectors;
  logic [LBA_W-1:0]  win_base;
  logic [FILL_W-1:0] win_fill;
  logic [TAG_W-1:0]  win_epoch;

  result_t     expected_q[$];
  int unsigned err_cnt = 0;
  int unsigned result_cnt = 0;
  int unsigned seek_cnt = 0;

  task automatic report_mismatch(string msg);
    if (err_cnt < 50) begin
      $display("%0t ns: result %0d: %s", $time, result_cnt, msg);
    end
    err_cnt++;
  endtask

  // A request inside the window hits; a miss below the base or beyond the slack restarts the window at lba.
  function automatic bit window_lookup(int unsigned lba, int unsigned last, output bit seek_flag);
    int unsigned head;
    head = win_base + win_fill;
    seek_flag = 1'b0;
    if (lba >= win_base && last <= head) return 1'b1;
    if (lba < win_base || lba > head + slack_sectors) begin
      win_epoch = win_epoch + 1'b1;
      win_base  = lba[LBA_W-1:0];
      win_fill  = '0;
      seek_flag = 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic result_t predict_result(cmd_e op, int unsigned lba, int unsigned cnt,
                                             logic [TAG_W-1:0] tag, int unsigned fetched);
    result_t     r;
    int unsigned head, last, n, room, left, total, floor_base, step;
    bit          seek_flag;
    r     = '0;
    total = disc_sectors;
    head  = win_base + win_fill;
    case (op)
      CMD_QUERY: begin
        if (!act_q || lba >= total) begin
          r.hit = 1'b1;
        end else begin
          last   = (cnt > total - lba) ? total : lba + cnt;
          r.hit  = window_lookup(lba, last, seek_flag);
          r.seek = seek_flag;
          if (r.hit) r.ring_slot = SLOT_W'(lba % RING_SECTORS);
        end
      end
      CMD_READ: begin
        if (act_q && cnt != 0) begin
          if (lba >= total) begin
            r.hit        = 1'b1;
            r.zero_count = CNT_W'(cnt);
          end else begin
            last   = (cnt > total - lba) ? total : lba + cnt;
            r.hit  = window_lookup(lba, last, seek_flag);
            r.seek = seek_flag;
            if (r.hit) begin
              r.ring_slot  = SLOT_W'(lba % RING_SECTORS);
              r.served     = CNT_W'(last - lba);
              r.zero_count = CNT_W'(cnt - (last - lba));
              floor_base   = (last > keep_sectors) ? last - keep_sectors : 0;
              if (floor_base > win_base) begin
                step = floor_base - win_base;
                if (step > win_fill) step = win_fill;
                win_base = LBA_W'(win_base + step);
                win_fill = FILL_W'(win_fill - step);
              end
            end
          end
        end
      end
      CMD_FETCH_REQ: begin
        if (act_q && head < total && win_fill < RING_SECTORS) begin
          n = (win_fill != 0) ? burst_sectors : first_sectors;
          if (n == 0) n = 1;
          else if (n > MAX_BURST) n = MAX_BURST;
          if (n > RING_SECTORS - win_fill) n = RING_SECTORS - win_fill;
          if (n > total - head) n = total - head;
          r.fetch_valid = 1'b1;
          r.fetch_lba   = LBA_W'(head);
          r.fetch_len   = LEN_W'(n);
          r.fetch_tag   = win_epoch;
          r.ring_slot   = SLOT_W'(head % RING_SECTORS);
        end
      end
      CMD_FETCH_DONE: begin
        if (act_q && tag == win_epoch) begin
          room = (win_fill < RING_SECTORS) ? RING_SECTORS - win_fill : 0;
          left = (head < total) ? total - head : 0;
          n    = fetched;
          if (n > room) n = room;
          if (n > left) n = left;
          win_fill    = FILL_W'(win_fill + n);
          r.hit       = 1'b1;
          r.ring_slot = SLOT_W'(head % RING_SECTORS);
        end
      end
      default: ;
    endcase
    r.level = win_fill;
    return r;
  endfunction

  always @(posedge clk_i) begin
    result_t got, want;
    if (!rst_ni) begin
      act_q         = 1'b0;
      disc_sectors  = '0;
      burst_sectors = BURST_LEN_RST;
      first_sectors = FIRST_LEN_RST;
      keep_sectors  = BEHIND_KEEP_RST;
      slack_sectors = SLACK_LEN_RST;
      win_base      = '0;
      win_fill      = '0;
      win_epoch     = '0;
      expected_q.delete();
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        got = m_tdata_i[$bits(result_t)-1:0];
        result_cnt++;
        if (expected_q.size() == 0) begin
          report_mismatch("result arrived with no request outstanding");
        end else begin
          want = expected_q.pop_front();
          if (got.hit !== want.hit)
            report_mismatch($sformatf("hit %0h, expected %0h", got.hit, want.hit));
          if (got.seek !== want.seek)
            report_mismatch($sformatf("seek %0h, expected %0h", got.seek, want.seek));
          if (got.ring_slot !== want.ring_slot)
            report_mismatch($sformatf("ring_slot %0h, expected %0h",
                                      got.ring_slot, want.ring_slot));
          if (got.served !== want.served)
            report_mismatch($sformatf("served %0h, expected %0h", got.served, want.served));
          if (got.zero_count !== want.zero_count)
            report_mismatch($sformatf("zero_count %0h, expected %0h",
                                      got.zero_count, want.zero_count));
          if (got.fetch_valid !== want.fetch_valid)
            report_mismatch($sformatf("fetch_valid %0h, expected %0h",
                                      got.fetch_valid, want.fetch_valid));
          if (got.fetch_lba !== want.fetch_lba)
            report_mismatch($sformatf("fetch_lba %0h, expected %0h",
                                      got.fetch_lba, want.fetch_lba));
          if (got.fetch_len !== want.fetch_len)
            report_mismatch($sformatf("fetch_len %0h, expected %0h",
                                      got.fetch_len, want.fetch_len));
          if (got.fetch_tag !== want.fetch_tag)
            report_mismatch($sformatf("fetch_tag %0h, expected %0h",
                                      got.fetch_tag, want.fetch_tag));
          if (got.level !== want.level)
            report_mismatch($sformatf("level %0h, expected %0h", got.level, want.level));
        end
      end
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (reg_idx_e'(paddr_i[4:2]))
          REG_ACTIVE: begin
            if (pwdata_i[0] && !act_q) begin
              win_base  = '0;
              win_fill  = '0;
              win_epoch = '0;
            end
            act_q = pwdata_i[0];
          end
          REG_TOTAL:       disc_sectors  = pwdata_i[LBA_W-1:0];
          REG_BURST_LEN:   burst_sectors = pwdata_i[LEN_W-1:0];
          REG_FIRST_LEN:   first_sectors = pwdata_i[LEN_W-1:0];
          REG_BEHIND_KEEP: keep_sectors  = pwdata_i[CNT_W-1:0];
          REG_SLACK_LEN:   slack_sectors = pwdata_i[CNT_W-1:0];
          default: ;
        endcase
      end
      if (s_tvalid_i && s_tready_i) begin
        want = predict_result(cmd_e'(s_tuser_i), s_tdata_i[LBA_W-1:0],
                              s_tdata_i[CNT_LSB +: CNT_W], s_tdata_i[TAG_LSB +: TAG_W],
                              s_tdata_i[FET_LSB +: LEN_W]);
        if (want.seek) seek_cnt++;
        expected_q.push_back(want);
      end
    end
    mismatches_o  <= err_cnt;
    outstanding_o <= expected_q.size();
    checked_o     <= result_cnt;
    seeks_o       <= seek_cnt;
    epoch_o       <= win_epoch;
    base_o        <= win_base;
    fill_o        <= win_fill;
  end

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import rawt_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 250000;
  localparam int unsigned LONG_HOLD   = 300;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic [1:0]            s_axis_tuser  = CMD_QUERY;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  psel          = 1'b0;
  logic                  penable       = 1'b0;
  logic                  pwrite        = 1'b0;
  logic [ADDR_W-1:0]     paddr         = '0;
  logic [31:0]           pwdata        = '0;
  logic [31:0]           prdata;
  logic                  pready;

  int unsigned      mismatches, outstanding, checked, seeks;
  logic [TAG_W-1:0]  epoch_now;
  logic [LBA_W-1:0]  base_now;
  logic [FILL_W-1:0] fill_now;

  int unsigned cycle_count   = 0;
  int unsigned sent          = 0;
  int unsigned disc_size     = 0;
  int unsigned gap_pct       = 0;
  int unsigned stall_pct     = 0;
  int unsigned hold_left     = 0;
  int unsigned holds_asked   = 0;
  int unsigned holds_granted = 0;
  bit          quiet         = 1'b0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  readahead_window_tracker_top DUT (.*);

  rawt_window_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_tvalid_i    (s_axis_tvalid),
    .s_tready_i    (s_axis_tready),
    .s_tdata_i     (s_axis_tdata),
    .s_tuser_i     (s_axis_tuser),
    .m_tvalid_i    (m_axis_tvalid),
    .m_tready_i    (m_axis_tready),
    .m_tdata_i     (m_axis_tdata),
    .psel_i        (psel),
    .penable_i     (penable),
    .pwrite_i      (pwrite),
    .paddr_i       (paddr),
    .pwdata_i      (pwdata),
    .pready_i      (pready),
    .mismatches_o  (mismatches),
    .outstanding_o (outstanding),
    .checked_o     (checked),
    .seeks_o       (seeks),
    .epoch_o       (epoch_now),
    .base_o        (base_now),
    .fill_o        (fill_now)
  );

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  // The result side stalls in random bursts, or for one long stretch when asked.
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      m_axis_tready <= 1'b0;
      hold_left     <= hold_left - 1;
    end else if (holds_granted != holds_asked) begin
      holds_granted <= holds_granted + 1;
      hold_left     <= LONG_HOLD - 1;
      m_axis_tready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 99) < stall_pct) begin
      hold_left     <= $urandom_range(0, 14);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  task automatic write_register(reg_idx_e idx, logic [31:0] value);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic apply_config(bit act, int unsigned total, int unsigned burst,
                              int unsigned first, int unsigned keep, int unsigned slack);
    write_register(REG_TOTAL, total);
    write_register(REG_BURST_LEN, burst);
    write_register(REG_FIRST_LEN, first);
    write_register(REG_BEHIND_KEEP, keep);
    write_register(REG_SLACK_LEN, slack);
    write_register(REG_ACTIVE, act);
    disc_size = total;
  endtask

  task automatic set_pace(int unsigned gap, int unsigned stall);
    gap_pct = gap;
    stall_pct <= stall;
  endtask

  task automatic send_cmd(cmd_e op, logic [LBA_W-1:0] lba, logic [CNT_W-1:0] cnt,
                          logic [TAG_W-1:0] tag, logic [LEN_W-1:0] fetched);
    int unsigned gap;
    if (!quiet && $urandom_range(0, 99) < gap_pct) begin
      gap = $urandom_range(1, 15);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {5'b0, fetched, tag, cnt, lba};
    do @(posedge clk_i); while (!s_axis_tready);
    sent++;
  endtask

  // Mostly requests around the current window, with seeks, disc-end and stale-tag traffic.
  task automatic send_mixed();
    int unsigned      pick;
    cmd_e             op;
    logic [LBA_W-1:0] lba;
    logic [CNT_W-1:0] cnt;
    logic [TAG_W-1:0] tag;
    logic [LEN_W-1:0] fetched;
    pick = $urandom_range(0, 99);
    if (pick < 25) op = CMD_QUERY;
    else if (pick < 50) op = CMD_READ;
    else if (pick < 72) op = CMD_FETCH_REQ;
    else op = CMD_FETCH_DONE;
    pick = $urandom_range(0, 99);
    if (pick < 55) lba = base_now + $urandom_range(0, fill_now + 40);
    else if (pick < 72) lba = base_now + fill_now + $urandom_range(0, 600);
    else if (pick < 82) lba = base_now - $urandom_range(1, 300);
    else if (pick < 92) lba = disc_size - $urandom_range(0, 40);
    else lba = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 70) cnt = $urandom_range(1, 64);
    else if (pick < 78) cnt = '0;
    else cnt = $urandom;
    tag = ($urandom_range(0, 99) < 85) ? epoch_now : $urandom;
    fetched = ($urandom_range(0, 99) < 5) ? 7'd0 : $urandom_range(1, 64);
    send_cmd(op, lba, cnt, tag, fetched);
  endtask

  task automatic wait_for_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    set_pace(0, 0);

    // With read-ahead off, queries hit and everything else is refused.
    send_cmd(CMD_QUERY, 24'd0, 12'd1, 8'd0, 7'd0);
    send_cmd(CMD_READ, 24'd5, 12'd3, 8'd0, 7'd0);
    send_cmd(CMD_FETCH_REQ, 24'd0, 12'd0, 8'd0, 7'd0);
    send_cmd(CMD_FETCH_DONE, 24'd0, 12'd0, 8'd0, 7'd8);
    wait_for_results();

    apply_config(1'b1, 200000, 32, 8, 256, 256);
    send_cmd(CMD_FETCH_REQ, 24'd0, 12'd0, 8'd0, 7'd0);
    send_cmd(CMD_FETCH_DONE, 24'd0, 12'd0, 8'd0, 7'd8);
    send_cmd(CMD_FETCH_DONE, 24'd0, 12'd0, 8'd255, 7'd64);
    send_cmd(CMD_FETCH_REQ, 24'd0, 12'd0, 8'd0, 7'd0);
    send_cmd(CMD_FETCH_DONE, 24'd0, 12'd0, 8'd0, 7'd64);
    send_cmd(CMD_FETCH_DONE, 24'd0, 12'd0, 8'd0, 7'd0);
    send_cmd(CMD_QUERY, 24'd2, 12'd4, 8'd0, 7'd0);
    send_cmd(CMD_QUERY, 24'd70, 12'd100, 8'd0, 7'd0);
    send_cmd(CMD_READ, 24'd0, 12'd0, 8'd0, 7'd0);
    send_cmd(CMD_READ, 24'd10, 12'd20, 8'd0, 7'd0);
    send_cmd(CMD_READ, 24'd200000, 12'd4095, 8'd0, 7'd0);
    send_cmd(CMD_QUERY, 24'hFFFFFF, 12'd4095, 8'd0, 7'd0);
    send_cmd(CMD_READ, 24'd199990, 12'd30, 8'd0, 7'd0);
    send_cmd(CMD_FETCH_REQ, 24'd0, 12'd0, 8'd0, 7'd0);
    send_cmd(CMD_FETCH_DONE, 24'd0, 12'd0, 8'd1, 7'd64);
    send_cmd(CMD_READ, 24'd199995, 12'd30, 8'd0, 7'd0);
    send_cmd(CMD_FETCH_REQ, 24'd0, 12'd0, 8'd0, 7'd0);
    send_cmd(CMD_QUERY, 24'd100, 12'd1, 8'd0, 7'd0);
    send_cmd(CMD_FETCH_DONE, 24'd0, 12'd0, 8'd1, 7'd5);
    wait_for_results();

    // Long output stall while requests keep coming, so the input side backs up.
    holds_asked <= holds_asked + 1;
    repeat (20) send_mixed();
    set_pace(15, 15);
    repeat (130) send_mixed();
    wait_for_results();

    apply_config(1'b1, 24'hFFFFFF, 64, 1, 0, 0);
    set_pace(0, 30);
    repeat (100) send_mixed();
    set_pace(10, 0);
    // Scattered requests; nearly every one restarts the window, so the tag wraps.
    repeat (260) begin
      if ($urandom_range(0, 9) == 0) begin
        if ($urandom_range(0, 1) != 0)
          send_cmd(CMD_FETCH_DONE, base_now + fill_now, '0, epoch_now, $urandom_range(0, 64));
        else
          send_cmd(CMD_FETCH_REQ, base_now + fill_now, '0, epoch_now, $urandom_range(0, 64));
      end else if ($urandom_range(0, 1) != 0) begin
        send_cmd(CMD_READ, $urandom, $urandom_range(1, 4095), $urandom, $urandom_range(0, 64));
      end else begin
        send_cmd(CMD_QUERY, $urandom, $urandom_range(1, 4095), $urandom, $urandom_range(0, 64));
      end
    end
    wait_for_results();

    apply_config(1'b1, 3000, 0, 127, 4095, 4095);
    set_pace(30, 10);
    repeat (120) send_mixed();
    wait_for_results();

    write_register(REG_ACTIVE, 0);
    apply_config(1'b1, 0, 1, 64, 256, 256);
    set_pace(5, 5);
    repeat (30) send_mixed();
    wait_for_results();

    // Fresh window, bursts appended until the ring is full.
    write_register(REG_ACTIVE, 0);
    apply_config(1'b1, 1000000, 64, 64, 4095, 0);
    set_pace(8, 8);
    for (int i = 0; i < 280; i++) begin
      if (i % 16 == 15) send_cmd(CMD_FETCH_REQ, '0, '0, '0, '0);
      else send_cmd(CMD_FETCH_DONE, $urandom, $urandom, epoch_now, 7'd64);
    end
    wait_for_results();

    apply_config(1'b0, 500000, 32, 8, 256, 256);
    set_pace(10, 10);
    repeat (30) send_mixed();
    wait_for_results();

    apply_config(1'b1, 500000, 16, 4, 128, 64);
    quiet <= 1'b1;
    repeat (80) send_mixed();
    wait_for_results();

    $display("Sent %0d requests across seven register settings; %0d results checked.",
             sent, checked);
    $display("The window restarted %0d times, the ring filled and the output stalled long.",
             seeks);
    if (mismatches == 0 && outstanding == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/rawt_pkg.sv
hdl/readahead_window_tracker_top.sv
tb/sv/rawt_window_checker.sv
tb/sv/testbench.sv
